>>> rtl/pkfrl_pkg.sv
// shared constants, verdict codes and the token type of the address table chain
`default_nettype none

package pkfrl_pkg;

   localparam int TABLE_DEPTH = 64;

   localparam int ADDR_W    = 24;
   localparam int TIME_W    = 64;
   localparam int IVL_W     = 16;
   localparam int CNT_W     = 7;
   localparam int VERDICT_W = 3;

   localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(1000);

   localparam logic [VERDICT_W-1:0] VERDICT_NEW        = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ELAPSED    = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_SUPPRESSED = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_OWN        = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_INVALID    = 3'd4;

   // token that walks the cell row, once to look up and once to update
   typedef struct packed {
      logic             vld;
      logic             upd;
      logic             hit;
      logic             hit_exp;
      logic             free;
      logic             do_upd;
      logic             do_ins;
      logic [CNT_W-1:0] cnt;
   } tok_type;

endpackage

`default_nettype wire

>>> rtl/pkfrl_cell.sv
// one table entry with its match, expiry and update logic
`default_nettype none

module pkfrl_cell
   import pkfrl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tok_type           tok_i,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [TIME_W-1:0] now,
   input  wire logic [IVL_W-1:0]  interval,
   output tok_type                tok_o
);

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic              mhit_ff, mhit_in;
   logic              mfree_ff, mfree_in;
   tok_type           tok_ff, tok_in;

   logic match;
   logic exp_cur;
   logic take_hit;
   logic wr_upd;
   logic wr_ins;
   logic exp_new;
   logic valid_new;

   assign match   = valid_ff && (key_ff == addr);
   assign exp_cur = (now - last_ff) >= TIME_W'(interval);

   always_comb begin
      tok_in    = tok_i;
      valid_in  = valid_ff;
      key_in    = key_ff;
      last_in   = last_ff;
      mhit_in   = mhit_ff;
      mfree_in  = mfree_ff;
      take_hit  = 1'b0;
      wr_upd    = 1'b0;
      wr_ins    = 1'b0;
      exp_new   = 1'b0;
      valid_new = 1'b0;
      if (tok_i.vld && !tok_i.upd) begin
         take_hit       = match && !tok_i.hit;
         mhit_in        = take_hit;
         mfree_in       = !valid_ff && !tok_i.free;
         tok_in.hit     = tok_i.hit || match;
         tok_in.hit_exp = take_hit ? exp_cur : tok_i.hit_exp;
         tok_in.free    = tok_i.free || !valid_ff;
      end else if (tok_i.vld && tok_i.upd) begin
         wr_upd    = mhit_ff && tok_i.do_upd;
         wr_ins    = mfree_ff && tok_i.do_ins;
         valid_new = valid_ff || wr_ins;
         // a freshly written time has age zero
         exp_new   = (wr_upd || wr_ins) ? (interval == '0) : exp_cur;
         if (wr_upd || wr_ins) begin
            last_in = now;
         end
         if (wr_ins) begin
            key_in = addr;
         end
         valid_in   = valid_new && !exp_new;
         tok_in.cnt = tok_i.cnt + {{(CNT_W-1){1'b0}}, valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         mhit_ff    <= 1'b0;
         mfree_ff   <= 1'b0;
         tok_ff     <= '0;
      end else begin
         valid_ff   <= valid_in;
         mhit_ff    <= mhit_in;
         mfree_ff   <= mfree_in;
         tok_ff     <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      last_ff <= last_in;
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

>>> rtl/pkfrl_chain.sv
// row of table cells with the token passed from each cell to the next
`default_nettype none

module pkfrl_chain
   import pkfrl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tok_type           tok_i,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [TIME_W-1:0] now,
   input  wire logic [IVL_W-1:0]  interval,
   output tok_type                tok_o
);

   tok_type tok_w [TABLE_DEPTH+1];

   assign tok_w[0] = tok_i;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      pkfrl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (tok_w[i]),
         .addr     (addr),
         .now      (now),
         .interval (interval),
         .tok_o    (tok_w[i+1])
      );
   end

   assign tok_o = tok_w[TABLE_DEPTH];

endmodule

`default_nettype wire

>>> rtl/per_key_forward_rate_limiter_top.sv
// per-address forward rate limiter: control, result registers and the cell row
// own-ship and invalid-coordinate requests: result in the cycle after accept,
//   next request may follow in the next cycle
// other requests: a lookup pass and an update pass through the cell row,
//   result once the update token leaves the cell row, busy until then
// synchronous reset clears all entries, the count and sets the interval to 1000 ms
`default_nettype none

module per_key_forward_rate_limiter_top
   import pkfrl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [ADDR_W-1:0]    req_aircraft_address,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   input  wire logic                 req_is_own_ship,
   input  wire logic                 req_coords_valid,
   input  wire logic                 csr_wr_en,
   input  wire logic [IVL_W-1:0]     csr_wr_data,
   output logic                      rsp_valid,
   output logic                      rsp_forward,
   output logic [VERDICT_W-1:0]      rsp_verdict,
   output logic                      rsp_table_full,
   output logic [CNT_W-1:0]          rsp_entries_in_use
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   tok_type               launch_ff, launch_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [IVL_W-1:0]      ivl_ff, ivl_in;
   logic                  res_fwd_ff, res_fwd_in;
   logic [VERDICT_W-1:0]  res_verdict_ff, res_verdict_in;
   logic                  res_full_ff, res_full_in;
   logic [CNT_W-1:0]      entries_ff, entries_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fwd_ff, rsp_fwd_in;
   logic [VERDICT_W-1:0]  rsp_verdict_ff, rsp_verdict_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;

   tok_type tok_end;
   logic    accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign ivl_in = csr_wr_en ? csr_wr_data : ivl_ff;

   pkfrl_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .tok_i    (launch_ff),
      .addr     (addr_ff),
      .now      (now_ff),
      .interval (ivl_ff),
      .tok_o    (tok_end)
   );

   always_comb begin
      state_in       = state_ff;
      launch_in      = '0;
      addr_in        = addr_ff;
      now_in         = now_ff;
      res_fwd_in     = res_fwd_ff;
      res_verdict_in = res_verdict_ff;
      res_full_in    = res_full_ff;
      entries_in     = entries_ff;
      rsp_valid_in   = 1'b0;
      rsp_fwd_in     = rsp_fwd_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in = req_aircraft_address;
               now_in  = req_now_ms;
               if (req_is_own_ship || !req_coords_valid) begin
                  rsp_valid_in   = 1'b1;
                  rsp_fwd_in     = 1'b0;
                  rsp_verdict_in = req_is_own_ship ? VERDICT_OWN : VERDICT_INVALID;
                  rsp_full_in    = 1'b0;
                  rsp_cnt_in     = entries_ff;
               end else begin
                  launch_in.vld = 1'b1;
                  state_in      = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (tok_end.vld && !tok_end.upd) begin
               launch_in.vld    = 1'b1;
               launch_in.upd    = 1'b1;
               launch_in.do_upd = tok_end.hit && tok_end.hit_exp;
               launch_in.do_ins = !tok_end.hit && tok_end.free;
               res_fwd_in       = !tok_end.hit || tok_end.hit_exp;
               res_full_in      = !tok_end.hit && !tok_end.free;
               if (!tok_end.hit) begin
                  res_verdict_in = VERDICT_NEW;
               end else if (tok_end.hit_exp) begin
                  res_verdict_in = VERDICT_ELAPSED;
               end else begin
                  res_verdict_in = VERDICT_SUPPRESSED;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (tok_end.vld && tok_end.upd) begin
               entries_in     = tok_end.cnt;
               rsp_valid_in   = 1'b1;
               rsp_fwd_in     = res_fwd_ff;
               rsp_verdict_in = res_verdict_ff;
               rsp_full_in    = res_full_ff;
               rsp_cnt_in     = tok_end.cnt;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         ivl_ff       <= INTERVAL_RESET;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         ivl_ff       <= ivl_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      now_ff         <= now_in;
      res_fwd_ff     <= res_fwd_in;
      res_verdict_ff <= res_verdict_in;
      res_full_ff    <= res_full_in;
      rsp_fwd_ff     <= rsp_fwd_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_forward        = rsp_fwd_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_entries_in_use = rsp_cnt_ff;

endmodule

`default_nettype wire

>>> rtl/pkfrl_checker.sv
// port-level checks on the rate limiter and the bind that attaches them
`default_nettype none

module pkfrl_checker
   import pkfrl_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 req_is_own_ship,
   input wire logic                 req_coords_valid,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_forward,
   input wire logic [VERDICT_W-1:0] rsp_verdict,
   input wire logic                 rsp_table_full
);

   // no result while a table request is in flight
   a_no_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_forward_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_forward) |->
         (rsp_verdict == VERDICT_NEW || rsp_verdict == VERDICT_ELAPSED))
      else $error("forwarded request with a non-forward verdict");

   a_full_is_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_forward && rsp_verdict == VERDICT_NEW))
      else $error("table full flag on a request that was not a new forward");

   a_own_ship_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_own_ship) |=>
         (rsp_valid && !rsp_forward && rsp_verdict == VERDICT_OWN))
      else $error("own-ship request did not give its result in the next cycle");

   a_table_req_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_is_own_ship && req_coords_valid) |=> (busy && !rsp_valid))
      else $error("table request did not raise busy");

endmodule

bind per_key_forward_rate_limiter_top pkfrl_checker u_pkfrl_checker (.*);

`default_nettype wire
